@@ src/tbp_pkg.sv @@
// Shared sizes, codes, types and helpers of the tournament branch predictor.
// No dependencies; the core and tbp_update refer to it by scoped names.
`default_nettype none

package tbp_pkg;

  // Table geometry
  localparam int PC_INDEX_BITS    = 15;
  localparam int LOCAL_HIST_BITS  = 9;
  localparam int GLOBAL_HIST_BITS = 16;
  localparam int CHOOSER_BITS     = 15;

  // Chooser index bits that come from the global history; any above are zero
  localparam int CH_COPY_BITS = (CHOOSER_BITS < GLOBAL_HIST_BITS) ? CHOOSER_BITS
                                                                  : GLOBAL_HIST_BITS;

  // Clear sweep covers the deepest table
  localparam int CLR_W_A = (PC_INDEX_BITS > LOCAL_HIST_BITS) ? PC_INDEX_BITS
                                                             : LOCAL_HIST_BITS;
  localparam int CLR_W_B = (GLOBAL_HIST_BITS > CHOOSER_BITS) ? GLOBAL_HIST_BITS
                                                             : CHOOSER_BITS;
  localparam int CLR_W   = (CLR_W_A > CLR_W_B) ? CLR_W_A : CLR_W_B;

  // Stream widths
  localparam int PC_W        = 32;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;

  // Two-bit saturating counters
  localparam int         CTR_W         = 2;
  localparam logic [1:0] CTR_MIN       = 2'd0;
  localparam logic [1:0] CTR_INIT      = 2'd1;
  localparam logic [1:0] CTR_TAKEN_MIN = 2'd2;
  localparam logic [1:0] CTR_MAX       = 2'd3;

  // Request kinds carried on tuser
  localparam logic ACT_PREDICT = 1'b0;
  localparam logic ACT_TRAIN   = 1'b1;

  // Result of one lookup and the write-back values for a train request
  typedef struct packed {
    logic                        pred;
    logic [CTR_W-1:0]            lctr_nxt;
    logic [CTR_W-1:0]            gctr_nxt;
    logic [CTR_W-1:0]            cctr_nxt;
    logic                        ch_we;
    logic [LOCAL_HIST_BITS-1:0]  lhist_nxt;
    logic [GLOBAL_HIST_BITS-1:0] ghist_nxt;
  } tbp_upd_t;

  function automatic logic [CTR_W-1:0] sat_move(input logic [CTR_W-1:0] c,
                                                input logic taken);
    logic [CTR_W-1:0] r;
    r = c;
    if (taken) begin
      if (c != CTR_MAX) r = c + 2'd1;
    end else begin
      if (c != CTR_MIN) r = c - 2'd1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/tournament_branch_predictor_core.sv @@
// Top level of the tournament branch predictor: sequencer, table RAMs, output register.
// Depends on tbp_pkg, tbp_ram and tbp_update.
//
//  Channel  | Dir | Signals                         | Contents (low bit first)
//  ---------+-----+---------------------------------+-------------------------------------
//  s_axis   | in  | tvalid, tready, tdata[39:0],    | tdata: pc[31:0], outcome[32], 0 pad
//           |     | tuser[0]                        | tuser: action (0 predict, 1 train)
//  m_axis   | out | tvalid, tready, tdata[7:0]      | tdata: prediction[0], 0 pad
//
// The result register loads after a request is accepted, once the local
// history read, then the local counter read that it addresses, are done;
// select and write-back happen at that load. tready returns the cycle after,
// so a new request is taken only once the previous one has loaded its
// result. The chain of two dependent RAM reads sets the pace.
// After reset a clear sweep over all 2**CLR_W = 65536 addresses loads the reset
// values into all tables; no request is taken until it ends.
// A result not yet taken holds the sequencer in its last step; outside the clear
// sweep, tables are written only when the result moves into the output register.
`default_nettype none

module tournament_branch_predictor_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  wire logic [tbp_pkg::IN_TDATA_W-1:0] s_axis_tdata_i,  // pc, outcome
  input  wire logic                           s_axis_tuser_i,  // action
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  output logic [tbp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o   // prediction
);

  localparam int PIB = tbp_pkg::PC_INDEX_BITS;
  localparam int LHB = tbp_pkg::LOCAL_HIST_BITS;
  localparam int GHB = tbp_pkg::GLOBAL_HIST_BITS;
  localparam int CHB = tbp_pkg::CHOOSER_BITS;
  localparam int CW  = tbp_pkg::CTR_W;

  typedef enum logic [1:0] {
    S_CLEAR,   // sweep reset values into every table
    S_IDLE,    // wait for a request; reads issue on acceptance
    S_LHIST,   // local history ready, read local counter
    S_LCTR     // all counters ready, select, write back, load result
  } state_e;

  state_e                   state_q, state_d;
  logic [tbp_pkg::CLR_W-1:0] clr_q, clr_d;
  logic [GHB-1:0]           ghist_q, ghist_d;
  logic                     out_valid_q, out_valid_d;
  logic                     out_pred_q, out_pred_d;

  // Request payload held while the lookup runs
  logic [PIB-1:0]           pc_idx_q;
  logic                     train_q;
  logic                     taken_q;

  logic                     accept;
  logic                     advance;
  logic                     clearing;
  logic                     upd_we;

  logic [LHB-1:0]           lh_rdata;
  logic [CW-1:0]            lc_rdata;
  logic [CW-1:0]            gc_rdata;
  logic [CW-1:0]            ch_rdata;
  logic [CHB-1:0]           ch_idx;

  // RAM write ports
  logic                     lh_we, lc_we, gc_we, ch_we;
  logic [PIB-1:0]           lh_waddr;
  logic [LHB-1:0]           lc_waddr;
  logic [GHB-1:0]           gc_waddr;
  logic [CHB-1:0]           ch_waddr;
  logic [LHB-1:0]           lh_wdata;
  logic [CW-1:0]            lc_wdata, gc_wdata, ch_wdata;

  tbp_pkg::tbp_upd_t        upd;

  // Handshakes
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign advance         = (state_q == S_LCTR) && (!out_valid_q || m_axis_tready_i);
  assign clearing        = (state_q == S_CLEAR);
  assign upd_we          = advance && (train_q == tbp_pkg::ACT_TRAIN);

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(tbp_pkg::OUT_TDATA_W-1){1'b0}}, out_pred_q};

  // Chooser index: low bits of the global history, zero above it
  always_comb begin
    ch_idx                             = '0;
    ch_idx[tbp_pkg::CH_COPY_BITS-1:0] = ghist_q[tbp_pkg::CH_COPY_BITS-1:0];
  end

  // Write ports: clear sweep or train write-back
  always_comb begin
    lh_we    = clearing || upd_we;
    lc_we    = clearing || upd_we;
    gc_we    = clearing || upd_we;
    ch_we    = clearing || (upd_we && upd.ch_we);
    if (clearing) begin
      lh_waddr = clr_q[PIB-1:0];
      lc_waddr = clr_q[LHB-1:0];
      gc_waddr = clr_q[GHB-1:0];
      ch_waddr = clr_q[CHB-1:0];
      lh_wdata = '0;
      lc_wdata = tbp_pkg::CTR_INIT;
      gc_wdata = tbp_pkg::CTR_INIT;
      ch_wdata = tbp_pkg::CTR_INIT;
    end else begin
      lh_waddr = pc_idx_q;
      lc_waddr = lh_rdata;
      gc_waddr = ghist_q;
      ch_waddr = ch_idx;
      lh_wdata = upd.lhist_nxt;
      lc_wdata = upd.lctr_nxt;
      gc_wdata = upd.gctr_nxt;
      ch_wdata = upd.cctr_nxt;
    end
  end

  // Local history per branch address
  tbp_ram #(.WIDTH(LHB), .DEPTH(2 ** PIB)) u_lhist_ram (
    .clk_i   (clk_i),
    .we_i    (lh_we),
    .waddr_i (lh_waddr),
    .wdata_i (lh_wdata),
    .re_i    (accept),
    .raddr_i (s_axis_tdata_i[PIB-1:0]),
    .rdata_o (lh_rdata)
  );

  // Local counters, addressed by the preceding local history read
  tbp_ram #(.WIDTH(CW), .DEPTH(2 ** LHB)) u_lctr_ram (
    .clk_i   (clk_i),
    .we_i    (lc_we),
    .waddr_i (lc_waddr),
    .wdata_i (lc_wdata),
    .re_i    (state_q == S_LHIST),
    .raddr_i (lh_rdata),
    .rdata_o (lc_rdata)
  );

  // Global counters, addressed by the global history
  tbp_ram #(.WIDTH(CW), .DEPTH(2 ** GHB)) u_gctr_ram (
    .clk_i   (clk_i),
    .we_i    (gc_we),
    .waddr_i (gc_waddr),
    .wdata_i (gc_wdata),
    .re_i    (accept),
    .raddr_i (ghist_q),
    .rdata_o (gc_rdata)
  );

  // Chooser counters
  tbp_ram #(.WIDTH(CW), .DEPTH(2 ** CHB)) u_chooser_ram (
    .clk_i   (clk_i),
    .we_i    (ch_we),
    .waddr_i (ch_waddr),
    .wdata_i (ch_wdata),
    .re_i    (accept),
    .raddr_i (ch_idx),
    .rdata_o (ch_rdata)
  );

  tbp_update u_update (
    .lctr_i   (lc_rdata),
    .gctr_i   (gc_rdata),
    .cctr_i   (ch_rdata),
    .taken_i  (taken_q),
    .lc_idx_i (lh_rdata),
    .ghist_i  (ghist_q),
    .upd_o    (upd)
  );

  // Sequencer next state
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    ghist_d     = ghist_q;
    out_valid_d = out_valid_q;
    out_pred_d  = out_pred_q;
    // drop the result once taken
    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (&clr_q) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = S_LHIST;
        end
      end
      S_LHIST: begin
        state_d = S_LCTR;
      end
      S_LCTR: begin
        if (advance) begin
          out_valid_d = 1'b1;
          out_pred_d  = upd.pred;
          if (train_q == tbp_pkg::ACT_TRAIN) begin
            ghist_d = upd.ghist_nxt;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      ghist_q     <= '0;
      out_valid_q <= 1'b0;
      out_pred_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      ghist_q     <= ghist_d;
      out_valid_q <= out_valid_d;
      out_pred_q  <= out_pred_d;
    end
  end

  // Capture the request payload on acceptance
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pc_idx_q <= s_axis_tdata_i[PIB-1:0];
      taken_q  <= s_axis_tdata_i[tbp_pkg::PC_W];
      train_q  <= s_axis_tuser_i;
    end
  end

endmodule

`default_nettype wire

@@ src/tbp_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module tbp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ src/tbp_update.sv @@
// Prediction select and train write-back values for one lookup.
// Depends on tbp_pkg for sizes, counter constants and the tbp_upd_t bundle.
`default_nettype none

module tbp_update (
  input  wire logic [tbp_pkg::CTR_W-1:0]            lctr_i,
  input  wire logic [tbp_pkg::CTR_W-1:0]            gctr_i,
  input  wire logic [tbp_pkg::CTR_W-1:0]            cctr_i,
  input  wire logic                                 taken_i,
  input  wire logic [tbp_pkg::LOCAL_HIST_BITS-1:0]  lc_idx_i,
  input  wire logic [tbp_pkg::GLOBAL_HIST_BITS-1:0] ghist_i,
  output tbp_pkg::tbp_upd_t                         upd_o
);

  logic lpred;
  logic gpred;

  assign lpred = (lctr_i >= tbp_pkg::CTR_TAKEN_MIN);
  assign gpred = (gctr_i >= tbp_pkg::CTR_TAKEN_MIN);

  always_comb begin
    upd_o           = '0;
    upd_o.pred      = (cctr_i <= tbp_pkg::CTR_INIT) ? lpred : gpred;
    upd_o.lctr_nxt  = tbp_pkg::sat_move(lctr_i, taken_i);
    upd_o.gctr_nxt  = tbp_pkg::sat_move(gctr_i, taken_i);
    upd_o.cctr_nxt  = cctr_i;
    upd_o.ch_we     = 1'b0;
    // move the chooser toward the side that was right, only on disagreement
    if (lpred != gpred) begin
      if (lpred == taken_i && cctr_i != tbp_pkg::CTR_MIN) begin
        upd_o.cctr_nxt = cctr_i - 2'd1;
        upd_o.ch_we    = 1'b1;
      end else if (gpred == taken_i && cctr_i != tbp_pkg::CTR_MAX) begin
        upd_o.cctr_nxt = cctr_i + 2'd1;
        upd_o.ch_we    = 1'b1;
      end
    end
    upd_o.lhist_nxt = {lc_idx_i[tbp_pkg::LOCAL_HIST_BITS-2:0], taken_i};
    upd_o.ghist_nxt = {ghist_i[tbp_pkg::GLOBAL_HIST_BITS-2:0], taken_i};
  end

endmodule

`default_nettype wire

@@ src/tbp_checker.sv @@
// Port-level checks for the tournament branch predictor, bound to the top level.
// Depends only on the top level's port list.
`default_nettype none

module tbp_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_axis_tvalid_i,
  input wire logic       s_axis_tready_o,
  input wire logic       m_axis_tvalid_o,
  input wire logic       m_axis_tready_i,
  input wire logic [7:0] m_axis_tdata_o
);

  logic s_acc;
  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;

  // one request at a time: no new request is taken while the table reads run
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready_o ##1 !s_axis_tready_o)
    else $error("request accepted while a lookup is in flight");

  // a result cannot appear sooner than the two dependent table reads allow
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !$rose(m_axis_tvalid_o) ##1 !$rose(m_axis_tvalid_o))
    else $error("result appeared before the table reads finished");

  // padding bits of the result stay zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[7:1] == 7'd0))
    else $error("result padding bits not zero");

  // a pending result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("pending result dropped or changed");

  // nothing is offered or taken while reset is held
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid_o && !s_axis_tready_o)
    else $error("handshake active during reset");

endmodule

bind tournament_branch_predictor_core tbp_checker u_tbp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire
